// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types and constants of the stable priority event queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package spq_pkg;

    // fixed field widths on the stream ports
    localparam int unsigned PRIO_W      = 3;
    localparam int unsigned EVT_W       = 16;
    localparam int unsigned OCC_W       = 5;
    localparam int unsigned S_TDATA_W   = 24;
    localparam int unsigned S_TUSER_W   = 1;
    localparam int unsigned M_TDATA_W   = 24;
    localparam int unsigned M_TUSER_W   = 2;

    // command carried in s_axis_tuser
    typedef enum logic {
        CMD_PUBLISH = 1'b0,
        CMD_TAKE    = 1'b1
    } spq_cmd_t;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [PRIO_W-1:0] prio;
    } spq_op_t;

endpackage

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, holds an event id and its priority
// depends on spq_pkg; instantiated DEPTH times by stable_priority_event_queue
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned ID_W = 16
) (
    input  logic              aclk,
    input  spq_op_t           op,
    input  logic              valid_i,
    input  logic [ID_W-1:0]   new_id,
    input  logic              left_ins,
    input  logic [ID_W-1:0]   left_id,
    input  logic [PRIO_W-1:0] left_prio,
    input  logic [ID_W-1:0]   right_id,
    input  logic [PRIO_W-1:0] right_prio,
    output logic              ins_o,
    output logic [ID_W-1:0]   id_o,
    output logic [PRIO_W-1:0] prio_o
);

    logic [ID_W-1:0]   id_reg,   id_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;

    // new event lands here or further up when this slot is empty or weaker
    assign ins_o = !valid_i || (op.prio > prio_reg);

    // shift toward the tail on insert, toward the head on removal
    always_comb begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (op.push && ins_o) begin
            if (left_ins) begin
                id_next   = left_id;
                prio_next = left_prio;
            end else begin
                id_next   = new_id;
                prio_next = op.prio;
            end
        end else if (op.pop) begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id_o   = id_reg;
    assign prio_o = prio_reg;

endmodule

// ===== rtl/stable_priority_event_queue.sv =====
// stable_priority_event_queue: bounded priority queue, highest priority first,
// fifo order within a level; built as a chain of spq_cell slots, uses spq_pkg
`timescale 1ns / 1ps
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: event_id, priority_req
//  m_axis   | out       | tuser: take_valid, rejected;
//           |           | tdata: out_event_id, out_priority, occupancy
//
//  one transfer per cycle in while s_axis_tready is high, one registered result
//  per transfer; every cell compares the new priority and shifts in the same cycle
//  the result register holds while m_axis_tready is low; a new transfer is
//  taken in the cycle the held result leaves
//  reset clears the fill count and the result valid; slot contents stay

module stable_priority_event_queue
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH           = 16,
    parameter int unsigned PRIORITY_LEVELS = 8,
    parameter int unsigned ID_BITS         = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] event_id, [18:16] priority_req
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [0] command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [15:0] out_event_id, [18:16] out_priority,
                                                // [23:19] occupancy
    output logic [M_TUSER_W-1:0] m_axis_tuser   // [0] take_valid, [1] rejected
);

    localparam int unsigned ID_W     = (ID_BITS < EVT_W) ? ID_BITS : EVT_W;
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned PRIO_MAX = PRIORITY_LEVELS - 1;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;

    logic              accept;
    spq_cmd_t          cmd;
    logic [ID_W-1:0]   in_id;
    logic [PRIO_W-1:0] in_prio_raw, in_prio;
    logic              full, empty;
    logic              take_ok, reject;
    spq_op_t           op;

    logic [ID_W-1:0]   cell_id   [DEPTH];
    logic [PRIO_W-1:0] cell_prio [DEPTH];
    logic              cell_ins  [DEPTH];

    // input unpacking and priority clamp
    assign accept      = s_axis_tvalid && s_axis_tready;
    assign cmd         = spq_cmd_t'(s_axis_tuser[0]);
    assign in_id       = s_axis_tdata[ID_W-1:0];
    assign in_prio_raw = s_axis_tdata[EVT_W +: PRIO_W];
    assign in_prio     = (32'(in_prio_raw) > PRIO_MAX) ? PRIO_W'(PRIO_MAX) : in_prio_raw;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign take_ok = accept && (cmd == CMD_TAKE) && !empty;
    assign reject  = accept && (cmd == CMD_PUBLISH) && full;

    // operation seen by the whole chain
    assign op.push = accept && (cmd == CMD_PUBLISH) && !full;
    assign op.pop  = take_ok;
    assign op.prio = in_prio;

    // chain of slots, head at index 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              l_ins;
        logic [ID_W-1:0]   l_id, r_id;
        logic [PRIO_W-1:0] l_prio, r_prio;

        if (i == 0) begin : g_head
            assign l_ins  = 1'b0;
            assign l_id   = in_id;
            assign l_prio = in_prio;
        end else begin : g_mid
            assign l_ins  = cell_ins[i-1];
            assign l_id   = cell_id[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_id   = '0;
            assign r_prio = '0;
        end else begin : g_body
            assign r_id   = cell_id[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .valid_i    (count_reg > CNT_W'(i)),
            .new_id     (in_id),
            .left_ins   (l_ins),
            .left_id    (l_id),
            .left_prio  (l_prio),
            .right_id   (r_id),
            .right_prio (r_prio),
            .ins_o      (cell_ins[i]),
            .id_o       (cell_id[i]),
            .prio_o     (cell_prio[i])
        );
    end

    // fill count
    always_comb begin
        count_next = count_reg;
        if (op.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // result register, one slot between the two sides
    assign s_axis_tready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            if (take_ok) begin
                m_data_next[EVT_W-1:0]       = EVT_W'(cell_id[0]);
                m_data_next[EVT_W +: PRIO_W] = cell_prio[0];
            end
            m_data_next[EVT_W+PRIO_W +: OCC_W] = OCC_W'(count_next);
            m_user_next = {reject, take_ok};
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== rtl/spq_checker.sv =====
// spq_checker: port-level assertions for stable_priority_event_queue
// depends on spq_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // a result waiting for the sink keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a result is either a take or a rejection, never both
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("take and reject flagged together");

    // a rejected publish leaves the queue full
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[23:19] == OCC_W'(DEPTH))
        else $error("rejection without a full queue");

    // without a taken entry the id and priority read zero
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[18:0] == '0)
        else $error("payload set without a taken entry");

    // a result goes out in the cycle after its input transfer
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("missing result after transfer");

endmodule

bind stable_priority_event_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
